// ===== hdl/tcp_scan_host_tracker_core_defines.svh =====
// assertion macros for the tcp scan host tracker
// used by the top level, expects clk and arst_n in scope
`ifndef TCP_SCAN_HOST_TRACKER_CORE_DEFINES_SVH
`define TCP_SCAN_HOST_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TSHT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define TSHT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define TSHT_ASSERT(lbl, prop)
`define TSHT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/tsht_pkg.sv =====
// shared types and constants of the tcp scan host tracker
// no dependencies
package tsht_pkg;
	localparam int TABLE_DEPTH  = 32;
	localparam int KEEP_ON_FULL = 20;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam logic [7:0] FLAG_SYN    = 8'h02;
	localparam logic [7:0] FLAG_ACK    = 8'h10;
	localparam logic [7:0] FLAG_SYNACK = 8'h12;
	localparam logic [15:0] CNT_MAX    = 16'hffff;
	localparam logic [15:0] THR_RESET  = 16'd10;
	localparam logic [7:0]  RATIO_RESET = 8'd3;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_RATIO     = 1'b1;

	typedef enum logic [1:0] {
		K_SYN    = 2'd0,
		K_ACK    = 2'd1,
		K_SYNACK = 2'd2,
		K_TICK   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_if_t;

	typedef struct packed {
		logic        host_valid;
		logic [31:0] host_address;
		logic        scan_alert;
		logic        ratio_alert;
		logic [15:0] syn_total;
		logic [15:0] synack_total;
		logic        last;
	} result_t;
endpackage

// ===== hdl/tsht_front.sv =====
// front end: classifies incoming words and queues table commands
// depends on tsht_pkg
module tsht_front import tsht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        command,
	input  logic [31:0] src_address,
	input  logic [31:0] dst_address,
	input  logic [7:0]  tcp_flags,
	output logic        busy,
	output cmd_if_t     head,
	input  logic        pop
);
	cmd_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              accept, push, do_pop;
	cmd_t              cls;
	logic              keep;

	assign busy   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept = start && !busy;

	always_comb begin
		cls.kind = K_TICK;
		cls.addr = dst_address;
		keep     = 1'b1;
		if (command) begin
			cls.kind = K_TICK;
		end else if (tcp_flags == FLAG_SYN) begin
			cls.kind = K_SYN;
			cls.addr = src_address;
		end else if (tcp_flags == FLAG_ACK) begin
			cls.kind = K_ACK;
		end else if (tcp_flags == FLAG_SYNACK) begin
			cls.kind = K_SYNACK;
		end else begin
			keep = 1'b0;
		end
	end

	assign push       = accept && keep;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== hdl/tsht_back.sv =====
// back end: host table search, counter update and tick walk
// depends on tsht_pkg
module tsht_back import tsht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_if_t     head,
	output logic        pop,
	input  logic [15:0] scan_threshold,
	input  logic [7:0]  ratio_limit,
	output logic        res_strobe,
	output result_t     res
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_WALK   = 4'b0100,
		S_CLOSE  = 4'b1000
	} state_t;

	state_t           state_q;
	cmd_t             cur_q;
	logic [CNT_W-1:0] count_q, idx_q;
	logic             strobe_q;
	result_t          res_q;

	logic [31:0] addr_mem   [TABLE_DEPTH];
	logic [15:0] syn_mem    [TABLE_DEPTH];
	logic [15:0] prior_mem  [TABLE_DEPTH];
	logic [15:0] ack_mem    [TABLE_DEPTH];
	logic [15:0] synack_mem [TABLE_DEPTH];
	logic        scan_rep_mem  [TABLE_DEPTH];
	logic        ratio_rep_mem [TABLE_DEPTH];

	logic [IDX_W-1:0] idx, slot;
	logic             at_end, hit, nearly_full;
	logic [15:0]      syn_rd, sak_rd, prior_rd;
	logic [24:0]      prod;
	logic             sa, ra;

	assign idx         = idx_q[IDX_W-1:0];
	assign at_end      = (idx_q == count_q);
	assign hit         = !at_end && (addr_mem[idx] == cur_q.addr);
	assign nearly_full = (count_q >= CNT_W'(TABLE_DEPTH - 1));
	assign slot        = nearly_full ? IDX_W'(KEEP_ON_FULL) : count_q[IDX_W-1:0];
	assign syn_rd      = syn_mem[idx];
	assign sak_rd      = synack_mem[idx];
	assign prior_rd    = prior_mem[idx];
	assign prod        = ({1'b0, ratio_limit} + 9'd1) * sak_rd;
	assign sa = !scan_rep_mem[idx] && (prior_rd == '0) && (syn_rd > scan_threshold);
	assign ra = !ratio_rep_mem[idx] && (sak_rd != '0) && ({9'd0, syn_rd} >= prod);

	assign pop        = (state_q == S_IDLE) && head.valid;
	assign res_strobe = strobe_q;
	assign res        = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SEARCH: begin
				if (hit) begin
					unique case (cur_q.kind)
						K_SYN:    if (syn_mem[idx] != CNT_MAX) syn_mem[idx] <= syn_mem[idx] + 16'd1;
						K_ACK:    if (ack_mem[idx] != CNT_MAX) ack_mem[idx] <= ack_mem[idx] + 16'd1;
						default:  if (synack_mem[idx] != CNT_MAX)
							synack_mem[idx] <= synack_mem[idx] + 16'd1;
					endcase
				end else if (at_end) begin
					addr_mem[slot]      <= cur_q.addr;
					prior_mem[slot]     <= '0;
					syn_mem[slot]       <= (cur_q.kind == K_SYN) ? 16'd1 : 16'd0;
					ack_mem[slot]       <= (cur_q.kind == K_ACK) ? 16'd1 : 16'd0;
					synack_mem[slot]    <= (cur_q.kind == K_SYNACK) ? 16'd1 : 16'd0;
					scan_rep_mem[slot]  <= 1'b0;
					ratio_rep_mem[slot] <= 1'b0;
				end
			end
			S_WALK: begin
				if (!at_end) begin
					if (!scan_rep_mem[idx]) prior_mem[idx] <= syn_rd;
					if (sa) scan_rep_mem[idx] <= 1'b1;
					if (ra) ratio_rep_mem[idx] <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head.cmd;
		if (state_q == S_WALK) begin
			res_q.host_valid   <= 1'b1;
			res_q.host_address <= addr_mem[idx];
			res_q.scan_alert   <= sa;
			res_q.ratio_alert  <= ra;
			res_q.syn_total    <= syn_rd;
			res_q.synack_total <= sak_rd;
			res_q.last         <= 1'b0;
		end else begin
			res_q <= '{host_valid: 1'b0, host_address: '0, scan_alert: 1'b0,
				ratio_alert: 1'b0, syn_total: '0, synack_total: '0, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (head.valid) begin
						state_q <= (head.cmd.kind == K_TICK) ? S_WALK : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						state_q <= S_IDLE;
					end else if (at_end) begin
						count_q <= nearly_full ? CNT_W'(KEEP_ON_FULL + 1) : count_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WALK: begin
					if (at_end) begin
						state_q <= S_CLOSE;
					end else begin
						strobe_q <= sa || ra;
						idx_q    <= idx_q + 1'b1;
					end
				end
				S_CLOSE: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/tcp_scan_host_tracker_core.sv =====
// top level of the tcp scan host tracker: apb registers, front and back ends
// depends on tsht_pkg, tsht_front, tsht_back and the defines header
// a packet word searches the host table, one table entry compared per cycle
// a tick walks the host table, one entry walked per cycle, then the closing word
// a two-word queue lets start be taken while the table logic is working
// arst_n clears the host count, queue and registers; table contents need no clearing
`include "tcp_scan_host_tracker_core_defines.svh"
module tcp_scan_host_tracker_core import tsht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] src_address,
	input  logic [31:0] dst_address,
	input  logic [7:0]  tcp_flags,
	output logic        strobe,
	output logic        host_valid,
	output logic [31:0] host_address,
	output logic        scan_alert,
	output logic        ratio_alert,
	output logic [15:0] syn_total,
	output logic [15:0] synack_total,
	output logic        last
);
	logic [15:0] threshold_q;
	logic [7:0]  ratio_q;
	cmd_if_t     head;
	logic        pop;
	result_t     res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
			ratio_q     <= RATIO_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_THRESHOLD: threshold_q <= pwdata[15:0];
				REG_RATIO:     ratio_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = {16'd0, threshold_q};
			REG_RATIO:     prdata = {24'd0, ratio_q};
			default:       prdata = '0;
		endcase
	end

	tsht_front u_front (
		.clk, .arst_n, .start, .command, .src_address, .dst_address, .tcp_flags,
		.busy, .head, .pop
	);

	tsht_back u_back (
		.clk, .arst_n, .head, .pop,
		.scan_threshold(threshold_q), .ratio_limit(ratio_q),
		.res_strobe(strobe), .res
	);

	assign host_valid   = res.host_valid;
	assign host_address = res.host_address;
	assign scan_alert   = res.scan_alert;
	assign ratio_alert  = res.ratio_alert;
	assign syn_total    = res.syn_total;
	assign synack_total = res.synack_total;
	assign last         = res.last;

	`TSHT_NEVER(a_last_with_host, strobe && last && host_valid)
	`TSHT_ASSERT(a_host_has_alert, strobe && host_valid |-> scan_alert || ratio_alert)
	`TSHT_ASSERT(a_close_ends_tick, strobe && last |=> !strobe)
endmodule
